>>> rtl/vlr_pkg.sv
package vlr_pkg;

  localparam int SampleBitsDef   = 24;
  localparam int PositionBitsDef = 24;

  localparam int PhaseBits = 18;
  localparam int GainBits  = 17;
  localparam int FadeBits  = 16;
  localparam int ModeBits  = 2;
  localparam int CfgIdxBits = 3;
  localparam int CfgDataBits = 32;

  localparam logic [PhaseBits-1:0] Unity   = 18'd65536;
  localparam logic [PhaseBits-1:0] StepMin = 18'd32768;
  localparam logic [PhaseBits-1:0] StepMax = 18'd131072;
  localparam logic [GainBits-1:0]  GainUnity = 17'd65536;
  localparam int SeamShift = 3;

  typedef enum logic [ModeBits-1:0] {
    ModeNone  = 2'd0,
    ModeLoop  = 2'd1,
    ModeFaded = 2'd2,
    ModeDecay = 2'd3
  } loop_mode_e;

  typedef enum logic [CfgIdxBits-1:0] {
    RegSpeed    = 3'd0,
    RegMode     = 3'd1,
    RegLength   = 3'd2,
    RegFade     = 3'd3,
    RegDecay    = 3'd4,
    RegFloor    = 3'd5
  } reg_idx_e;

endpackage

>>> rtl/vlr_front.sv
// Front: holds configuration, accepts source frames, handles priming and
// loop position / pass gain bookkeeping, then issues one job to the queue.
module vlr_front #(
  parameter int SampleBits   = vlr_pkg::SampleBitsDef,
  parameter int PositionBits = vlr_pkg::PositionBitsDef,
  localparam int JobBits = 2*SampleBits + PositionBits + 2*vlr_pkg::PhaseBits
                         + vlr_pkg::GainBits + 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [SampleBits-1:0]     in_sample_i,
  input  logic                      in_restart_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [vlr_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [vlr_pkg::CfgDataBits-1:0] cfg_data_i,
  output logic [vlr_pkg::PhaseBits-1:0]   speed_o,
  output logic [vlr_pkg::ModeBits-1:0]    mode_o,
  output logic [PositionBits-1:0]         length_o,
  output logic [vlr_pkg::FadeBits-1:0]    fade_o,
  output logic                      job_valid_o,
  input  logic                      job_ready_i,
  output logic [JobBits-1:0]        job_o
);
  localparam int PB = vlr_pkg::PhaseBits;
  localparam int GB = vlr_pkg::GainBits;

  logic [PB-1:0] speed_q;
  logic [vlr_pkg::ModeBits-1:0] mode_q;
  logic [PositionBits-1:0] len_q;
  logic [vlr_pkg::FadeBits-1:0] fade_q;
  logic [GB-1:0] decay_q, floor_q;

  logic signed [SampleBits-1:0] cur_q, nxt_q;
  logic [PB-1:0] phase_q;
  logic [1:0] prime_q;
  logic [PositionBits-1:0] pos_q;
  logic [GB-1:0] gain_q;
  logic stop_q;

  // gain update is split off so the multiply product is registered before use
  logic busy_q, gupd_q;
  logic [GB+GB-1:0] gprod_q;

  assign cfg_ready_o = 1'b1;
  assign speed_o = speed_q;
  assign mode_o  = mode_q;
  assign length_o = len_q;
  assign fade_o  = fade_q;

  assign in_ready_o = !busy_q && !job_valid_o;
  wire in_fire = in_valid_i && in_ready_o;

  logic [1:0] prime_eff;
  logic [PositionBits-1:0] pos_inc;
  logic [GB+GB-1:0] gfull;
  logic [GB-1:0] gnew;
  always_comb begin
    prime_eff = in_restart_i ? 2'd0 : prime_q;
    pos_inc = pos_q + PositionBits'(1);
    gfull = gprod_q + (GB+GB)'(32768);
    gnew = (|gfull[GB+GB-1:16+GB]) ? {GB{1'b1}} : gfull[16+GB-1:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= PB'(65536); mode_q <= vlr_pkg::ModeNone; len_q <= '0;
      fade_q <= 16'd480; decay_q <= 17'd52429; floor_q <= 17'd655;
      cur_q <= '0; nxt_q <= '0; phase_q <= '0; prime_q <= '0; pos_q <= '0;
      gain_q <= vlr_pkg::GainUnity; stop_q <= 1'b0;
      busy_q <= 1'b0; gupd_q <= 1'b0; job_valid_o <= 1'b0; gprod_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          vlr_pkg::RegSpeed:  speed_q <= cfg_data_i[PB-1:0];
          vlr_pkg::RegMode:   mode_q  <= cfg_data_i[vlr_pkg::ModeBits-1:0];
          vlr_pkg::RegLength: len_q   <= cfg_data_i[PositionBits-1:0];
          vlr_pkg::RegFade:   fade_q  <= cfg_data_i[vlr_pkg::FadeBits-1:0];
          vlr_pkg::RegDecay:  decay_q <= cfg_data_i[GB-1:0];
          vlr_pkg::RegFloor:  floor_q <= cfg_data_i[GB-1:0];
          default: ;
        endcase
      end
      if (job_valid_o && job_ready_i) job_valid_o <= 1'b0;
      if (in_fire) begin
        if (in_restart_i) stop_q <= 1'b0;
        if (prime_eff == 2'd0) begin
          cur_q <= in_sample_i; prime_q <= 2'd1;
        end else if (prime_eff == 2'd1) begin
          nxt_q <= in_sample_i; phase_q <= '0; pos_q <= PositionBits'(2);
          gain_q <= vlr_pkg::GainUnity; prime_q <= 2'd2; job_valid_o <= 1'b1;
        end else begin
          phase_q <= (phase_q >= vlr_pkg::Unity) ? phase_q - vlr_pkg::Unity : '0;
          cur_q <= nxt_q; nxt_q <= in_sample_i;
          if (mode_q[1] && len_q != '0) begin
            if (pos_inc >= len_q) begin
              pos_q <= '0;
              if (mode_q == vlr_pkg::ModeDecay) begin
                gprod_q <= gain_q * decay_q;
                gupd_q <= 1'b1; busy_q <= 1'b1;
              end else job_valid_o <= 1'b1;
            end else begin
              pos_q <= pos_inc; job_valid_o <= 1'b1;
            end
          end else job_valid_o <= 1'b1;
        end
      end
      if (gupd_q) begin
        gupd_q <= 1'b0; busy_q <= 1'b0; job_valid_o <= 1'b1;
        if (gnew < floor_q) begin
          gain_q <= '0; stop_q <= 1'b1;
        end else gain_q <= gnew;
      end
      // phase after emission is taken from the final phase the front precomputed in the job
      if (job_valid_o && job_ready_i) phase_q <= job_o[JobBits-1 -: PB];
    end
  end

  // phase returned through the job: front precomputes final phase
  logic [PB-1:0] step, ph1, ph_end;
  always_comb begin
    step = (speed_q < vlr_pkg::StepMin) ? vlr_pkg::StepMin :
           (speed_q > vlr_pkg::StepMax) ? vlr_pkg::StepMax : speed_q;
    ph1 = phase_q + step;
    if (phase_q >= vlr_pkg::Unity) ph_end = phase_q;
    else if (ph1 >= vlr_pkg::Unity) ph_end = ph1;
    else ph_end = ph1 + step;
  end

  assign job_o = {ph_end, stop_q, gain_q, pos_q, phase_q, nxt_q, cur_q,
                  (phase_q < vlr_pkg::Unity)};
endmodule

>>> rtl/vlr_queue.sv
// Two-entry job queue between front and back.
module vlr_queue #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [Width-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [Width-1:0] rd_data_o
);
  logic [Width-1:0] mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  wire wr = wr_valid_i && wr_ready_o;
  wire rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) if (wr) mem_q[wp_q] <= wr_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

>>> rtl/vlr_back.sv
// Back: per output, interpolate, apply seam or pass gain, saturate.
// The seam gain uses a restoring divider, one quotient bit per cycle.
module vlr_back #(
  parameter int SampleBits   = vlr_pkg::SampleBitsDef,
  parameter int PositionBits = vlr_pkg::PositionBitsDef,
  localparam int JobBits = 2*SampleBits + PositionBits + 2*vlr_pkg::PhaseBits
                         + vlr_pkg::GainBits + 2
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [vlr_pkg::PhaseBits-1:0] speed_i,
  input  logic [vlr_pkg::ModeBits-1:0]  mode_i,
  input  logic [PositionBits-1:0]       length_i,
  input  logic [vlr_pkg::FadeBits-1:0]  fade_i,
  input  logic                    job_valid_i,
  output logic                    job_ready_o,
  input  logic [JobBits-1:0]      job_i,
  output logic                    m_valid_o,
  input  logic                    m_ready_i,
  output logic [SampleBits-1:0]   m_sample_o,
  output logic                    m_stop_o,
  output logic                    m_last_o
);
  localparam int PB = vlr_pkg::PhaseBits;
  localparam int GB = vlr_pkg::GainBits;
  localparam int SB = SampleBits;
  localparam int NB = PositionBits + 16;   // dividend width
  localparam int CB = $clog2(NB + 1);

  typedef enum logic [2:0] {SIdle, SInterp, SDiv, SGain, SOut} state_e;
  state_e st_q;

  logic signed [SB-1:0] cur_q, nxt_q;
  logic [PB-1:0] ph_q, step_q;
  logic [PositionBits-1:0] pos_q;
  logic [GB-1:0] pgain_q, g_q;
  logic stop_q, more_q;
  logic signed [SB+PB+1:0] prod_q;
  logic signed [SB+1:0] v_q;
  logic [NB-1:0] rem_q, quo_q;
  logic [PositionBits:0] f_q;
  logic [CB-1:0] cnt_q;

  assign job_ready_o = (st_q == SIdle);

  // job fields
  logic [PB-1:0] j_phase;
  logic [PositionBits-1:0] j_pos;
  logic [GB-1:0] j_gain;
  logic j_stop, j_emit;
  logic signed [SB-1:0] j_cur, j_nxt;
  always_comb begin
    {j_stop, j_gain, j_pos, j_phase, j_nxt, j_cur, j_emit} = job_i[JobBits-PB-1:0];
  end

  // seam length and numerator
  logic [PositionBits+3:0] len8;
  logic [PositionBits:0] f_c, num_c;
  logic seam_on;
  always_comb begin
    len8 = {fade_i, 3'b000} > (PositionBits+4)'(length_i) ? '0 : '1;
    f_c = (len8 != '0) ? (PositionBits+1)'(fade_i)
                       : (PositionBits+1)'(length_i >> vlr_pkg::SeamShift);
    seam_on = (mode_i == vlr_pkg::ModeFaded) && (length_i != '0);
    if ((PositionBits+1)'(pos_q) < f_c) num_c = (PositionBits+1)'(pos_q);
    else if ((PositionBits+1)'(pos_q) > (PositionBits+1)'(length_i) - f_c)
      num_c = (pos_q >= length_i) ? '0 : (PositionBits+1)'(length_i - pos_q);
    else num_c = '1;   // marker for unity
  end

  logic signed [SB:0] diff;
  logic signed [SB+1:0] interp;
  logic signed [SB+PB+1:0] rnd;
  logic [NB:0] trial;
  logic signed [SB+GB+2:0] gprod, grnd;
  logic signed [SB+1:0] gv;
  logic signed [SB-1:0] sat;
  always_comb begin
    diff = (SB+1)'(nxt_q) - (SB+1)'(cur_q);
    rnd = prod_q + (SB+PB+2)'(32768);
    interp = (SB+2)'(cur_q) + (SB+2)'(rnd >>> 16);
    trial = {rem_q, quo_q[NB-1]} - (NB+1)'(f_q);
    gprod = (SB+GB+3)'(v_q) * $signed({1'b0, g_q});
    grnd = gprod + (SB+GB+3)'(32768);
    gv = (SB+2)'(grnd >>> 16);
    if (gv > $signed((SB+2)'({1'b0, {(SB-1){1'b1}}}))) sat = {1'b0, {(SB-1){1'b1}}};
    else if (gv < -$signed((SB+2)'({1'b1, {(SB-1){1'b0}}}))) sat = {1'b1, {(SB-1){1'b0}}};
    else sat = gv[SB-1:0];
  end

  logic [PB-1:0] step_c;
  always_comb
    step_c = (speed_i < vlr_pkg::StepMin) ? vlr_pkg::StepMin :
             (speed_i > vlr_pkg::StepMax) ? vlr_pkg::StepMax : speed_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; m_valid_o <= 1'b0; cnt_q <= '0; more_q <= 1'b0;
    end else begin
      if (m_valid_o && m_ready_i) m_valid_o <= 1'b0;
      case (st_q)
        SIdle: if (job_valid_i && j_emit) begin
          cur_q <= j_cur; nxt_q <= j_nxt; ph_q <= j_phase; pos_q <= j_pos;
          pgain_q <= j_gain; stop_q <= j_stop; step_q <= step_c;
          st_q <= SInterp;
        end
        SInterp: begin
          prod_q <= diff * $signed({1'b0, ph_q});
          st_q <= SDiv;
          cnt_q <= '0;
        end
        SDiv: begin
          if (cnt_q == '0) begin
            v_q <= interp;
            if (seam_on && f_c != '0 && num_c != '1) begin
              quo_q <= NB'({num_c, 16'd0}); rem_q <= '0; f_q <= f_c;
              cnt_q <= CB'(1);
            end else begin
              g_q <= (mode_i == vlr_pkg::ModeDecay && !seam_on) ? pgain_q
                                                               : vlr_pkg::GainUnity;
              st_q <= SGain;
            end
          end else begin
            if (!trial[NB]) rem_q <= trial[NB-1:0];
            else rem_q <= {rem_q[NB-2:0], quo_q[NB-1]};
            quo_q <= {quo_q[NB-2:0], !trial[NB]};
            if (cnt_q == CB'(NB)) st_q <= SGain;
            cnt_q <= cnt_q + CB'(1);
          end
        end
        SGain: begin
          if (cnt_q == CB'(NB+1)) g_q <= quo_q[GB-1:0];
          st_q <= SOut;
        end
        SOut: if (!m_valid_o || m_ready_i) begin
          m_sample_o <= sat; m_stop_o <= stop_q;
          m_valid_o <= 1'b1;
          more_q <= (ph_q + step_q) < vlr_pkg::Unity && !more_q;
          m_last_o <= !((ph_q + step_q) < vlr_pkg::Unity && !more_q);
          if ((ph_q + step_q) < vlr_pkg::Unity && !more_q) begin
            ph_q <= ph_q + step_q; st_q <= SInterp;
          end else begin
            more_q <= 1'b0; st_q <= SIdle;
          end
        end
        default: st_q <= SIdle;
      endcase
    end
  end
endmodule

>>> rtl/varispeed_loop_resampler.sv
// Path: front, two-entry job queue, back; each sample is interpolated, then
// given the faded seam gain from the divider (restoring, one bit a cycle)
// or the pass gain, and saturated. Throughput: the front takes no new frame
// while its job waits for the queue or a pass-gain update is busy; the back
// takes no job until it has sent the none, one or two samples of the last.
// Reset: asynchronous, active low; config returns to defaults, unprimed.
module varispeed_loop_resampler #(
  parameter int SampleBits   = vlr_pkg::SampleBitsDef,
  parameter int PositionBits = vlr_pkg::PositionBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [((SampleBits+7)/8)*8-1:0] s_axis_tdata,  // source_sample
  input  logic s_axis_tuser,                              // restart
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [((SampleBits+7)/8)*8-1:0] m_axis_tdata,  // out_sample
  output logic m_axis_tuser,                              // stop_request
  output logic m_axis_tlast,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [vlr_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [vlr_pkg::CfgDataBits-1:0] cfg_data_i
);
  localparam int JobBits = 2*SampleBits + PositionBits + 2*vlr_pkg::PhaseBits
                         + vlr_pkg::GainBits + 2;
  localparam int TB = ((SampleBits+7)/8)*8;

  logic [vlr_pkg::PhaseBits-1:0] speed;
  logic [vlr_pkg::ModeBits-1:0] mode;
  logic [PositionBits-1:0] len;
  logic [vlr_pkg::FadeBits-1:0] fade;
  logic fv, fr, bv, br;
  logic [JobBits-1:0] fj, bj;
  logic [SampleBits-1:0] osamp;

  vlr_front #(.SampleBits(SampleBits), .PositionBits(PositionBits)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_sample_i(s_axis_tdata[SampleBits-1:0]), .in_restart_i(s_axis_tuser),
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .speed_o(speed), .mode_o(mode), .length_o(len), .fade_o(fade),
    .job_valid_o(fv), .job_ready_i(fr), .job_o(fj));

  vlr_queue #(.Width(JobBits)) u_queue (
    .clk_i, .rst_ni, .wr_valid_i(fv), .wr_ready_o(fr), .wr_data_i(fj),
    .rd_valid_o(bv), .rd_ready_i(br), .rd_data_o(bj));

  vlr_back #(.SampleBits(SampleBits), .PositionBits(PositionBits)) u_back (
    .clk_i, .rst_ni, .speed_i(speed), .mode_i(mode), .length_i(len),
    .fade_i(fade), .job_valid_i(bv), .job_ready_o(br), .job_i(bj),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .m_sample_o(osamp), .m_stop_o(m_axis_tuser), .m_last_o(m_axis_tlast));

  assign m_axis_tdata = TB'(osamp);
endmodule

>>> rtl/vlr_checker.sv
module vlr_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic m_axis_tlast,
  input logic m_axis_tuser,
  input logic s_axis_tvalid,
  input logic s_axis_tready
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("valid dropped");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tlast))
    else $error("last changed");
  a_user: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tuser))
    else $error("user changed");
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid)
    else $error("input beat withdrawn");
endmodule

bind varispeed_loop_resampler vlr_checker u_chk (.*);
